>>> rtl/ir_sample_pair_decoder_macros.svh
// assertion helpers for the sample pair decoder
`ifndef IR_SAMPLE_PAIR_DECODER_MACROS_SVH
`define IR_SAMPLE_PAIR_DECODER_MACROS_SVH

`ifndef SYNTH

// plain property, checked on every rising clock edge outside reset
`define ISPD_ASSERT(name, expr, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (expr)) else $error(msg);

// implication within the same cycle
`define ISPD_ASSERT_IMP(name, ante, cons, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

`else

`define ISPD_ASSERT(name, expr, msg)
`define ISPD_ASSERT_IMP(name, ante, cons, msg)

`endif

`endif

>>> rtl/ispd_pkg.sv
package ispd_pkg;

   localparam int BYTE_W  = 8;
   localparam int COUNT_W = 16;
   localparam int DUR_W   = 24;

   // count value that resynchronises the stream
   localparam logic [COUNT_W-1:0] RESYNC_COUNT = 16'hFFFF;

   // duration of the inserted space marker
   localparam logic [DUR_W-1:0] MARKER_DURATION = 24'hFFFFFF;

   // scale 21.3333 split as 21 + fraction; fraction held as ceil(0.3333 * 2^30)
   localparam int FRAC_W      = 29;
   localparam int SCALE_SHIFT = 30;
   localparam int PROD_W      = COUNT_W + FRAC_W;
   localparam logic [FRAC_W-1:0] SCALE_FRAC = 29'd357878150;

endpackage

>>> rtl/ispd_scale.sv
module ispd_scale
   import ispd_pkg::*;
(
   input  logic [COUNT_W-1:0] count,
   output logic [DUR_W-1:0]   duration
);

   logic [PROD_W-1:0] frac_prod;
   logic [DUR_W-1:0]  int_part;
   logic [DUR_W-1:0]  frac_part;
   logic [DUR_W-1:0]  count_ext;

   // fractional part of the scale: one multiply, keep the bits above the binary point
   assign frac_prod = PROD_W'(count) * PROD_W'(SCALE_FRAC);
   assign frac_part = DUR_W'(frac_prod[PROD_W-1:SCALE_SHIFT]);

   // integer part of the scale: count * 21 as shifts and adds
   assign count_ext = DUR_W'(count);
   assign int_part  = (count_ext << 4) + (count_ext << 2) + count_ext;

   assign duration = int_part + frac_part;

endmodule

>>> rtl/ir_sample_pair_decoder.sv
// channel   ports                                        direction
// req       req_valid req_ready req_rx_byte              in, one byte per transaction
// rsp       rsp_valid rsp_ready rsp_duration             out, one duration per transaction
//           rsp_is_pulse rsp_last
//
// a byte is taken every cycle while the count stage can move on; a count with
// a pending marker holds that stage until both results are out (marker, then duration)
// the low byte reaches its first result through the count stage, then the result
// register fed by one constant multiply
// reset is synchronous and active high; it clears the pairing state and both stages
// a stalled result holds the count stage; high bytes are still taken meanwhile
`include "ir_sample_pair_decoder_macros.svh"

module ir_sample_pair_decoder
   import ispd_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [BYTE_W-1:0]  req_rx_byte,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [DUR_W-1:0]   rsp_duration,
   output logic               rsp_is_pulse,
   output logic               rsp_last
);

   // pairing state
   logic              expect_high_ff, expect_high_in;
   logic [BYTE_W-1:0] high_part_ff, high_part_in;
   logic              next_is_pulse_ff, next_is_pulse_in;
   logic              marker_sent_ff, marker_sent_in;

   // count stage
   logic               s1_valid_ff, s1_valid_in;
   logic               s1_marker_ff, s1_marker_in;
   logic               s1_pulse_ff, s1_pulse_in;
   logic [COUNT_W-1:0] s1_count_ff, s1_count_in;

   // result register
   logic               rsp_valid_ff, rsp_valid_in;
   logic [DUR_W-1:0]   rsp_duration_ff, rsp_duration_in;
   logic               rsp_is_pulse_ff, rsp_is_pulse_in;
   logic               rsp_last_ff, rsp_last_in;

   logic               accept;
   logic [COUNT_W-1:0] count;
   logic               load_s1;
   logic               out_free;
   logic               s1_emit;
   logic               s1_done;
   logic               s1_free;
   logic [DUR_W-1:0]   scaled;

   // handshake and stage movement
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign s1_emit   = s1_valid_ff && out_free;
   assign s1_done   = s1_emit && !s1_marker_ff;
   assign s1_free   = !s1_valid_ff || s1_done;
   assign req_ready = expect_high_ff || s1_free;
   assign accept    = req_valid && req_ready;
   assign count     = {high_part_ff, req_rx_byte};
   assign load_s1   = accept && !expect_high_ff && (count != RESYNC_COUNT);

   // byte pairing, resync and alternation
   always_comb begin
      expect_high_in   = expect_high_ff;
      high_part_in     = high_part_ff;
      next_is_pulse_in = next_is_pulse_ff;
      marker_sent_in   = marker_sent_ff;
      if (accept) begin
         if (expect_high_ff) begin
            high_part_in   = req_rx_byte;
            expect_high_in = 1'b0;
         end else begin
            expect_high_in = 1'b1;
            if (count == RESYNC_COUNT) begin
               next_is_pulse_in = 1'b1;
               marker_sent_in   = 1'b0;
            end else begin
               next_is_pulse_in = !next_is_pulse_ff;
               marker_sent_in   = 1'b1;
            end
         end
      end
   end

   // count stage control
   always_comb begin
      s1_valid_in  = s1_valid_ff;
      s1_marker_in = s1_marker_ff;
      s1_pulse_in  = s1_pulse_ff;
      s1_count_in  = s1_count_ff;
      if (load_s1) begin
         s1_valid_in  = 1'b1;
         s1_marker_in = !marker_sent_ff;
         s1_pulse_in  = next_is_pulse_ff;
         s1_count_in  = count;
      end else begin
         if (s1_done) begin
            s1_valid_in = 1'b0;
         end
         if (s1_emit) begin
            s1_marker_in = 1'b0;
         end
      end
   end

   ispd_scale u_scale (
      .count    (s1_count_ff),
      .duration (scaled)
   );

   // result register: marker first where pending, then the scaled duration
   always_comb begin
      rsp_valid_in    = rsp_valid_ff;
      rsp_duration_in = rsp_duration_ff;
      rsp_is_pulse_in = rsp_is_pulse_ff;
      rsp_last_in     = rsp_last_ff;
      if (s1_emit) begin
         rsp_valid_in = 1'b1;
         if (s1_marker_ff) begin
            rsp_duration_in = MARKER_DURATION;
            rsp_is_pulse_in = 1'b0;
            rsp_last_in     = 1'b0;
         end else begin
            rsp_duration_in = scaled;
            rsp_is_pulse_in = s1_pulse_ff;
            rsp_last_in     = 1'b1;
         end
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         expect_high_ff   <= 1'b1;
         high_part_ff     <= '0;
         next_is_pulse_ff <= 1'b1;
         marker_sent_ff   <= 1'b0;
         s1_valid_ff      <= 1'b0;
         s1_marker_ff     <= 1'b0;
         rsp_valid_ff     <= 1'b0;
      end else begin
         expect_high_ff   <= expect_high_in;
         high_part_ff     <= high_part_in;
         next_is_pulse_ff <= next_is_pulse_in;
         marker_sent_ff   <= marker_sent_in;
         s1_valid_ff      <= s1_valid_in;
         s1_marker_ff     <= s1_marker_in;
         rsp_valid_ff     <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      s1_pulse_ff     <= s1_pulse_in;
      s1_count_ff     <= s1_count_in;
      rsp_duration_ff <= rsp_duration_in;
      rsp_is_pulse_ff <= rsp_is_pulse_in;
      rsp_last_ff     <= rsp_last_in;
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_duration = rsp_duration_ff;
   assign rsp_is_pulse = rsp_is_pulse_ff;
   assign rsp_last     = rsp_last_ff;

   // checks
   `ISPD_ASSERT_IMP(a_marker_pending_valid, s1_marker_ff, s1_valid_ff, "marker pending in empty stage")
   `ISPD_ASSERT_IMP(a_nonlast_is_marker, rsp_valid_ff && !rsp_last_ff, (rsp_duration_ff == MARKER_DURATION) && !rsp_is_pulse_ff, "non-final result is not the marker")
   `ISPD_ASSERT_IMP(a_marker_has_follower, rsp_valid_ff && rsp_ready && !rsp_last_ff, s1_valid_ff && !s1_marker_ff, "marker sent without its duration waiting")

endmodule

>>> tb/ir_sample_pair_decoder_checker.sv
`timescale 1ns / 1ps

module ir_sample_pair_decoder_checker
   import ispd_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   input  logic              req_ready,
   input  logic [BYTE_W-1:0] req_rx_byte,
   input  logic              rsp_valid,
   input  logic              rsp_ready,
   input  logic [DUR_W-1:0]  rsp_duration,
   input  logic              rsp_is_pulse,
   input  logic              rsp_last,
   output int                failures,
   output int                pending
);

   // count to microseconds: floor(count * 21.3333)
   localparam longint unsigned US_PER_COUNT_NUM = 213333;
   localparam longint unsigned US_PER_COUNT_DEN = 10000;

   typedef struct packed {
      logic [DUR_W-1:0] duration;
      logic             is_pulse;
      logic             fin;
   } duration_type;

   // pairing state of the decoder as seen from outside
   logic              want_high;
   logic [BYTE_W-1:0] held_high;
   logic              pulse_next;
   logic              marker_done;

   duration_type durations_q[$];
   int           mismatch_count;

   function automatic logic [DUR_W-1:0] count_to_us(logic [COUNT_W-1:0] count);
      longint unsigned us;
      us = longint'(count) * US_PER_COUNT_NUM / US_PER_COUNT_DEN;
      return us[DUR_W-1:0];
   endfunction

   // one received byte: pair it up and queue the durations it yields
   function automatic void decode_byte(logic [BYTE_W-1:0] rx);
      logic [COUNT_W-1:0] count;
      duration_type       d;
      if (want_high) begin
         held_high = rx;
         want_high = 1'b0;
         return;
      end
      want_high = 1'b1;
      count = {held_high, rx};
      // resync: next count is a pulse and the marker goes out again
      if (count == RESYNC_COUNT) begin
         pulse_next = 1'b1;
         marker_done = 1'b0;
         return;
      end
      if (!marker_done) begin
         d.duration = MARKER_DURATION;
         d.is_pulse = 1'b0;
         d.fin = 1'b0;
         durations_q.push_back(d);
         marker_done = 1'b1;
      end
      d.duration = count_to_us(count);
      d.is_pulse = pulse_next;
      d.fin = 1'b1;
      durations_q.push_back(d);
      pulse_next = !pulse_next;
   endfunction

   // compare one result transaction with the oldest queued duration
   function automatic void check_result();
      duration_type d;
      if (durations_q.size() == 0) begin
         $display("%0t: unexpected result: expected none, got duration %0d pulse %0b last %0b",
                  $time, rsp_duration, rsp_is_pulse, rsp_last);
         mismatch_count++;
         return;
      end
      d = durations_q.pop_front();
      if (rsp_duration !== d.duration) begin
         $display("%0t: duration: expected %0d, got %0d", $time, d.duration, rsp_duration);
         mismatch_count++;
      end
      if (rsp_is_pulse !== d.is_pulse) begin
         $display("%0t: is_pulse: expected %0b, got %0b", $time, d.is_pulse, rsp_is_pulse);
         mismatch_count++;
      end
      if (rsp_last !== d.fin) begin
         $display("%0t: last: expected %0b, got %0b", $time, d.fin, rsp_last);
         mismatch_count++;
      end
   endfunction

   // monitor both channels
   always @(posedge clock) begin
      if (reset) begin
         want_high = 1'b1;
         held_high = '0;
         pulse_next = 1'b1;
         marker_done = 1'b0;
         durations_q.delete();
      end else begin
         if (req_valid && req_ready) decode_byte(req_rx_byte);
         if (rsp_valid && rsp_ready) check_result();
      end
      failures <= mismatch_count;
      pending <= durations_q.size();
   end

   initial begin
      mismatch_count = 0;
   end

endmodule

>>> tb/ir_sample_pair_decoder_tb.sv
`timescale 1ns / 1ps

module ir_sample_pair_decoder_tb;
   import ispd_pkg::*;

   localparam int BYTE_TARGET = 1800;
   localparam int STALL_LIMIT = 2000;
   localparam int TAIL_CYCLES = 8;

   logic              clock;
   logic              reset;
   logic              req_valid;
   logic              req_ready;
   logic [BYTE_W-1:0] req_rx_byte;
   logic              rsp_valid;
   logic              rsp_ready;
   logic [DUR_W-1:0]  rsp_duration;
   logic              rsp_is_pulse;
   logic              rsp_last;
   int                failures;
   int                pending;

   int bytes_sent;
   bit burst_mode;

   ir_sample_pair_decoder dut (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_rx_byte  (req_rx_byte),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_duration (rsp_duration),
      .rsp_is_pulse (rsp_is_pulse),
      .rsp_last     (rsp_last)
   );

   ir_sample_pair_decoder_checker checker_i (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_rx_byte  (req_rx_byte),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_duration (rsp_duration),
      .rsp_is_pulse (rsp_is_pulse),
      .rsp_last     (rsp_last),
      .failures     (failures),
      .pending      (pending)
   );

   // clock
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // idle length: mostly none or short, now and then long
   function automatic int idle_len();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   // present one byte and hold it until the transaction completes
   task automatic send_byte(input logic [BYTE_W-1:0] rx);
      int gap;
      gap = burst_mode ? 0 : idle_len();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_rx_byte <= rx;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      bytes_sent++;
   endtask

   task automatic send_count(input logic [COUNT_W-1:0] count);
      send_byte(count[15:8]);
      send_byte(count[7:0]);
   endtask

   // result side back-pressure
   initial begin
      int run;
      int stall;
      rsp_ready <= 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         run = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 120) : $urandom_range(1, 8);
         rsp_ready <= 1'b1;
         repeat (run) @(posedge clock);
         stall = idle_len();
         if (stall > 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
      end
   end

   // watchdog on cycles with no transaction on either channel
   initial begin
      int quiet;
      quiet = 0;
      while (quiet < STALL_LIMIT) begin
         @(posedge clock);
         if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) quiet = 0;
         else quiet++;
      end
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

   // stimulus and verdict
   initial begin
      int r;
      logic [COUNT_W-1:0] count;
      reset <= 1'b1;
      req_valid <= 1'b0;
      req_rx_byte <= '0;
      bytes_sent = 0;
      burst_mode = 1'b0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // directed: zero count behind the marker, smallest and largest counts
      send_count(16'h0000);
      send_count(16'h0001);
      send_count(16'hFFFE);
      // resync twice in a row, then marker again before the next pulse
      send_count(RESYNC_COUNT);
      send_count(RESYNC_COUNT);
      send_count(16'h7FFF);
      send_count(16'h8000);
      send_count(16'hFF00);
      send_count(16'h00FF);
      // resync on a pulse slot, then alternating bit patterns
      send_count(RESYNC_COUNT);
      send_count(16'hAA55);
      send_count(16'h55AA);

      // random counts with resyncs and the odd stray byte that shifts the pairing
      while (bytes_sent < BYTE_TARGET) begin
         if ($urandom_range(0, 99) == 0) burst_mode = !burst_mode;
         if (bytes_sent >= BYTE_TARGET / 2 && bytes_sent < BYTE_TARGET / 2 + 2) begin
            // let every outstanding result drain before carrying on
            req_valid <= 1'b0;
            @(posedge clock);
            while (pending != 0) @(posedge clock);
         end
         r = $urandom_range(0, 99);
         if (r < 5) begin
            send_count(RESYNC_COUNT);
         end else if (r < 8) begin
            send_byte(8'($urandom_range(0, 255)));
         end else if (r < 18) begin
            case ($urandom_range(0, 3))
               0: count = 16'($urandom_range(0, 3));
               1: count = 16'hFFFE - 16'($urandom_range(0, 3));
               2: count = {8'hFF, 8'($urandom_range(0, 254))};
               default: count = {8'($urandom_range(0, 254)), 8'hFF};
            endcase
            send_count(count);
         end else begin
            send_count(16'($urandom_range(0, 16'hFFFF)));
         end
      end
      req_valid <= 1'b0;

      // drain, then allow for anything left in flight
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);
      if (failures == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule
